// ----- rtl/core/dtsp_pkg.sv -----
// ---------------------------------------------------------------------------
// dtsp_pkg
// Shared types, constants and helpers for the devicetree structure-block
// token parser.
// ---------------------------------------------------------------------------
`default_nettype none

package dtsp_pkg;

    // Blob address space in bytes, as a power of two (12..32)
    localparam int BLOB_BYTES_LOG2 = 24;
    localparam int BYTE_W          = BLOB_BYTES_LOG2;
    localparam int POS_W           = BLOB_BYTES_LOG2 - 2;
    localparam int OFF_EXT_W       = (BYTE_W > 24) ? BYTE_W : 24;
    // (2^24 - 1 + 3) >> 2 needs 23 bits
    localparam int SKIP_W          = 23;

    localparam logic [31:0] DTB_MAGIC      = 32'hD00D_FEED;
    localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
    localparam logic [31:0] TOK_END_NODE   = 32'd2;
    localparam logic [31:0] TOK_PROP       = 32'd3;
    localparam logic [31:0] TOK_NOP        = 32'd4;
    localparam logic [31:0] TOK_END        = 32'd9;

    localparam logic [1:0] KIND_PROP      = 2'd0;
    localparam logic [1:0] KIND_END       = 2'd1;
    localparam logic [1:0] KIND_HDR_ERR   = 2'd2;
    localparam logic [1:0] KIND_BAD_TOKEN = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_SEEK   = 3'd2,
        PH_TOKEN  = 3'd3,
        PH_NAME   = 3'd4,
        PH_PLEN   = 3'd5,
        PH_PNAME  = 3'd6,
        PH_SKIP   = 3'd7
    } phase_t;

    typedef struct packed {
        logic        first_word;
        logic [31:0] blob_word;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] node_name_offset;
        logic [23:0] prop_name_offset;
        logic [23:0] value_offset;
        logic [23:0] value_length;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } walk_res_t;

    // Low 24 bits of a blob byte offset, zero-extended for small blobs
    function automatic logic [23:0] off24(input logic [BYTE_W-1:0] x);
        logic [OFF_EXT_W-1:0] t;
        t = OFF_EXT_W'(x);
        return t[23:0];
    endfunction

    function automatic logic offset_bad(input logic [31:0] off);
        return (off < 32'd16) || (off[1:0] != 2'b00);
    endfunction

    function automatic logic has_zero_byte(input logic [31:0] w);
        return (w[31:24] == 8'h00) || (w[23:16] == 8'h00) ||
               (w[15:8] == 8'h00) || (w[7:0] == 8'h00);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dtsp_in_stage.sv -----
// ---------------------------------------------------------------------------
// dtsp_in_stage
// Input register: captures one blob word transaction and holds it until
// the walker consumes it.
// ---------------------------------------------------------------------------
`default_nettype none

module dtsp_in_stage
    import dtsp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_item,
    input  wire logic     consume,
    output logic          item_valid,
    output in_item_t      item
);

    logic     in_valid_reg, in_valid_next;
    in_item_t in_item_reg;

    assign s_ready    = !in_valid_reg || consume;
    assign item_valid = in_valid_reg;
    assign item       = in_item_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dtsp_walker.sv -----
// ---------------------------------------------------------------------------
// dtsp_walker
// Parser state and per-word decode: header check, seek to the structure
// block, token walk and value skipping.
// ---------------------------------------------------------------------------
`default_nettype none

module dtsp_walker
    import dtsp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     fire,
    input  wire in_item_t item,
    output walk_res_t     res
);

    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    word_pos_reg, word_pos_next;
    logic [BYTE_W-1:0]   struct_start_reg, struct_start_next;
    logic [BYTE_W-1:0]   strings_start_reg, strings_start_next;
    logic [BYTE_W-1:0]   node_off_reg, node_off_next;
    logic [23:0]         pend_len_reg, pend_len_next;
    logic [SKIP_W-1:0]   skip_reg, skip_next;

    phase_t              ph;
    logic [POS_W-1:0]    pos;
    logic [BYTE_W-1:0]   byte_pos;
    logic [BYTE_W-1:0]   next_byte_pos;
    logic [31:0]         w;
    logic                at_token;
    logic [24:0]         len_round;
    logic [SKIP_W-1:0]   skip_calc;

    always_comb begin
        w             = item.blob_word;
        // a first word restarts the parser on this very word
        pos           = item.first_word ? '0 : word_pos_reg;
        ph            = item.first_word ? PH_HEADER : phase_reg;
        byte_pos      = {pos, 2'b00};
        next_byte_pos = {pos + POS_W'(1), 2'b00};
        at_token      = (ph == PH_TOKEN) ||
                        ((ph == PH_SEEK) && (byte_pos == struct_start_reg));
        // value words, rounded up; the sum needs one bit above the length
        len_round     = {1'b0, pend_len_reg} + 25'd3;
        skip_calc     = len_round[24:2];

        phase_next         = ph;
        word_pos_next      = pos + POS_W'(1);
        struct_start_next  = struct_start_reg;
        strings_start_next = strings_start_reg;
        node_off_next      = node_off_reg;
        pend_len_next      = pend_len_reg;
        skip_next          = skip_reg;
        res                = '0;

        unique case (ph)
            PH_HEADER: begin
                if (pos == POS_W'(0)) begin
                    if (w != DTB_MAGIC) begin
                        res.valid     = 1'b1;
                        res.item.kind = KIND_HDR_ERR;
                        phase_next    = PH_IDLE;
                    end
                end else if (pos == POS_W'(2)) begin
                    struct_start_next = offset_bad(w) ? '0 : BYTE_W'(w);
                end else if (pos == POS_W'(3)) begin
                    if (offset_bad(w) || (struct_start_reg == '0)) begin
                        res.valid     = 1'b1;
                        res.item.kind = KIND_HDR_ERR;
                        phase_next    = PH_IDLE;
                    end else begin
                        strings_start_next = BYTE_W'(w);
                        phase_next         = PH_SEEK;
                    end
                end
            end
            PH_NAME: begin
                if (has_zero_byte(w)) begin
                    phase_next = PH_TOKEN;
                end
            end
            PH_PLEN: begin
                pend_len_next = w[23:0];
                phase_next    = PH_PNAME;
            end
            PH_PNAME: begin
                res.valid                 = 1'b1;
                res.item.kind             = KIND_PROP;
                res.item.node_name_offset = off24(node_off_reg);
                res.item.prop_name_offset = off24(strings_start_reg) + w[23:0];
                res.item.value_offset     = off24(next_byte_pos);
                res.item.value_length     = pend_len_reg;
                skip_next                 = skip_calc;
                phase_next = (skip_calc == '0) ? PH_TOKEN : PH_SKIP;
            end
            PH_SKIP: begin
                if (skip_reg != '0) begin
                    skip_next = skip_reg - SKIP_W'(1);
                end
                if (skip_reg <= SKIP_W'(1)) begin
                    phase_next = PH_TOKEN;
                end
            end
            PH_IDLE, PH_SEEK, PH_TOKEN: begin
            end
            default: begin
            end
        endcase

        // seek falls into the token decode on the structure block's first word
        if (at_token) begin
            phase_next = PH_TOKEN;
            priority if (w == TOK_BEGIN_NODE) begin
                node_off_next = next_byte_pos;
                phase_next    = PH_NAME;
            end else if (w == TOK_PROP) begin
                phase_next = PH_PLEN;
            end else if ((w == TOK_NOP) || (w == TOK_END_NODE)) begin
                phase_next = PH_TOKEN;
            end else if (w == TOK_END) begin
                res.valid     = 1'b1;
                res.item.kind = KIND_END;
                phase_next    = PH_IDLE;
            end else begin
                res.valid     = 1'b1;
                res.item.kind = KIND_BAD_TOKEN;
                phase_next    = PH_IDLE;
            end
        end

        res.valid = res.valid && fire;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            word_pos_reg      <= '0;
            struct_start_reg  <= '0;
            strings_start_reg <= '0;
            node_off_reg      <= '0;
            pend_len_reg      <= '0;
            skip_reg          <= '0;
        end else if (fire) begin
            phase_reg         <= phase_next;
            word_pos_reg      <= word_pos_next;
            struct_start_reg  <= struct_start_next;
            strings_start_reg <= strings_start_next;
            node_off_reg      <= node_off_next;
            pend_len_reg      <= pend_len_next;
            skip_reg          <= skip_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dtsp_out_stage.sv -----
// ---------------------------------------------------------------------------
// dtsp_out_stage
// Result register: holds one result transaction until the sink takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module dtsp_out_stage
    import dtsp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      load,
    input  wire walk_res_t res,
    output logic           out_free,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_item   = out_item_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = load && res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (out_free && load && res.valid) begin
            out_item_reg <= res.item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/devicetree_struct_token_parser.sv -----
// Path: each word is held in the input register and its result in the result register.
// Throughput: one blob word per cycle; the only stall is a held result
//   register, which stops the walker stage while m_ready is low.
// Reset: aresetn (synchronous, active low) empties both registers and puts
//   the parser idle with all offsets zero; words wait for a first_word.
// ---------------------------------------------------------------------------
// devicetree_struct_token_parser
// Walks the structure block of a flattened devicetree blob streamed one
// big-endian word per transaction and reports properties, end and errors.
// ---------------------------------------------------------------------------
`default_nettype none

module devicetree_struct_token_parser
    import dtsp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_item,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_item
);

    logic      item_valid;
    in_item_t  item;
    logic      out_free;
    logic      fire;
    walk_res_t res;

    assign fire = item_valid && out_free;

    dtsp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .consume    (out_free),
        .item_valid (item_valid),
        .item       (item)
    );

    dtsp_walker u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .res     (res)
    );

    dtsp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .res      (res),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

`default_nettype wire

// ----- rtl/core/dtsp_checker.sv -----
// ---------------------------------------------------------------------------
// dtsp_checker
// Port-level checks for the devicetree structure-block token parser.
// ---------------------------------------------------------------------------
`default_nettype none

module dtsp_checker
    import dtsp_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_item_t  s_item,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_item
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // nothing comes out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // end and error reports carry no offsets
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.kind != KIND_PROP) |->
            (m_item.node_name_offset == 24'd0) && (m_item.prop_name_offset == 24'd0) &&
            (m_item.value_offset == 24'd0) && (m_item.value_length == 24'd0))
        else $error("status result with nonzero fields");

    // node and value offsets are word positions
    a_prop_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.kind == KIND_PROP) |->
            (m_item.value_offset[1:0] == 2'b00) && (m_item.node_name_offset[1:0] == 2'b00))
        else $error("unaligned offset in property result");

endmodule

bind devicetree_struct_token_parser dtsp_checker u_dtsp_checker (.*);

`default_nettype wire
